FILE: rtl/prra_pkg.sv
package prra_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int NUM_LEVELS_DEF   = 8;

  // fixed field widths of the channel words
  localparam int MASK_W     = 8;
  localparam int PREV_W     = 3;
  localparam int PRIO_W     = 3;
  localparam int PRIO_REG_W = 24;

  // register port
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_CHANNEL_PRIORITIES = 1'b0;

  typedef struct packed {
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
  } apb_req_t;

endpackage

FILE: rtl/prra_cfg.sv
module prra_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  prra_pkg::apb_req_t            req,
  output logic [prra_pkg::PRIO_REG_W-1:0] prio_r,
  output logic [prra_pkg::DATA_W-1:0]   prdata
);
  import prra_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = req.paddr[ADDR_W-1:2];
  assign wr_en   = req.psel && req.penable && req.pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prio_r <= '0;
    end else if (wr_en && (reg_idx == REG_CHANNEL_PRIORITIES)) begin
      prio_r <= req.pwdata[PRIO_REG_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CHANNEL_PRIORITIES: prdata = DATA_W'(prio_r);
      default:                prdata = '0;
    endcase
  end

endmodule

FILE: rtl/prra_pick.sv
module prra_pick #(
  parameter int NUM_CHANNELS = prra_pkg::NUM_CHANNELS_DEF,
  parameter int NUM_LEVELS   = prra_pkg::NUM_LEVELS_DEF
) (
  input  logic [prra_pkg::MASK_W-1:0]       elig_mask,
  input  logic [prra_pkg::PREV_W-1:0]       prev,
  input  logic [prra_pkg::PRIO_REG_W-1:0]   prio,
  input  logic [$clog2(NUM_CHANNELS+1)-1:0] last_r   [NUM_LEVELS],
  output logic [$clog2(NUM_CHANNELS+1)-1:0] last_nxt [NUM_LEVELS],
  output logic [$clog2(NUM_CHANNELS+1)-1:0] granted,
  output logic                              none
);
  import prra_pkg::*;

  localparam int CH_W   = $clog2(NUM_CHANNELS + 1);
  localparam int LV_W   = $clog2(NUM_LEVELS);
  // channels past the mask width can never win, so only these are scanned
  localparam int SCAN_N = (NUM_CHANNELS < MASK_W) ? NUM_CHANNELS : MASK_W;
  localparam int SC_W   = $clog2(SCAN_N);

  logic [LV_W-1:0]   lvl [SCAN_N];
  logic [SCAN_N-1:0] hit;
  logic [SCAN_N-1:0] elig;
  logic [PREV_W:0]   start_full;
  logic [SC_W-1:0]   start;

  // per-channel level and "is last served at its level"
  for (genvar c = 0; c < SCAN_N; c++) begin : g_chan
    logic [PRIO_W-1:0]     raw;
    logic [NUM_LEVELS-1:0] eq;

    assign raw     = prio[PRIO_W*c +: PRIO_W];
    assign lvl[c]  = (32'(raw) >= NUM_LEVELS) ? LV_W'(NUM_LEVELS - 1) : LV_W'(raw);
    assign elig[c] = elig_mask[c];

    for (genvar l = 0; l < NUM_LEVELS; l++) begin : g_lvl
      assign eq[l] = (lvl[c] == LV_W'(l)) && (last_r[l] == CH_W'(c));
    end
    assign hit[c] = |eq;
  end

  assign start_full = {1'b0, prev} + (PREV_W+1)'(1);
  assign start      = (32'(start_full) >= SCAN_N) ? '0 : SC_W'(start_full);

  logic                  have;
  logic [SC_W-1:0]       sel;
  logic [LV_W-1:0]       sel_lvl;
  logic                  sel_hit;
  logic [NUM_LEVELS-1:0] inv;

  // one pass over the rotated scan order, at most eight steps
  always_comb begin
    logic [SC_W:0]   sum;
    logic [SC_W-1:0] ch;
    have    = 1'b0;
    sel     = '0;
    sel_lvl = '0;
    sel_hit = 1'b0;
    inv     = '0;
    for (int k = 0; k < SCAN_N; k++) begin
      sum = {1'b0, start} + (SC_W+1)'(k);
      ch  = (sum >= (SC_W+1)'(SCAN_N)) ? SC_W'(sum - (SC_W+1)'(SCAN_N)) : SC_W'(sum);
      if (elig[ch]) begin
        if (!have || (lvl[ch] < sel_lvl)) begin
          have    = 1'b1;
          sel     = ch;
          sel_lvl = lvl[ch];
          sel_hit = hit[ch];
        end else if ((lvl[ch] == sel_lvl) && sel_hit) begin
          // step past the channel last served here; entry is dropped
          sel          = ch;
          sel_hit      = 1'b0;
          inv[sel_lvl] = 1'b1;
        end
      end
    end
  end

  for (genvar l = 0; l < NUM_LEVELS; l++) begin : g_upd
    assign last_nxt[l] = (have && (sel_lvl == LV_W'(l))) ? CH_W'(sel) :
                         inv[l] ? CH_W'(NUM_CHANNELS) : last_r[l];
  end

  assign none    = !have;
  assign granted = have ? CH_W'(sel) : CH_W'(NUM_CHANNELS);

endmodule

FILE: rtl/priority_round_robin_channel_arbiter.sv
// channel  | direction | handshake          | word
// in_      | input     | in_valid/in_stall  | four channel masks, previous channel
// out_     | output    | out_valid/out_stall| granted channel, none-eligible flag
// apb      | input     | psel/penable       | channel priorities register at 0x0
//
// one grant per cycle while out_stall is low: each word is registered, picked by a single pass over
// up to eight channels, and the grant registered on the output side
// out_valid rises as the accepted word moves into the output register; the last-served table
// updates as the word moves to the output register, so the next word sees it
// out_stall holds the output register and then the input register
// synchronous active-low reset clears valids, priorities and the table
module priority_round_robin_channel_arbiter #(
  parameter int NUM_CHANNELS = prra_pkg::NUM_CHANNELS_DEF,
  parameter int NUM_LEVELS   = prra_pkg::NUM_LEVELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [prra_pkg::MASK_W-1:0]       in_device_connected_mask,
  input  logic [prra_pkg::MASK_W-1:0]       in_controller_connected_mask,
  input  logic [prra_pkg::MASK_W-1:0]       in_rx_ready_mask,
  input  logic [prra_pkg::MASK_W-1:0]       in_tx_nonempty_mask,
  input  logic [prra_pkg::PREV_W-1:0]       in_previous_channel,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [$clog2(NUM_CHANNELS+1)-1:0] out_granted_channel,
  output logic                              out_none_eligible,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [prra_pkg::ADDR_W-1:0]       paddr,
  input  logic [prra_pkg::DATA_W-1:0]       pwdata,
  output logic [prra_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);
  import prra_pkg::*;

  localparam int CH_W = $clog2(NUM_CHANNELS + 1);

  apb_req_t              apb_req;
  logic [PRIO_REG_W-1:0] prio_r;

  logic                  in_v_r;
  logic [MASK_W-1:0]     elig_r;
  logic [PREV_W-1:0]     prev_r;
  logic                  out_v_r;
  logic [CH_W-1:0]       granted_r;
  logic                  none_r;
  logic [CH_W-1:0]       last_r   [NUM_LEVELS];
  logic [CH_W-1:0]       last_nxt [NUM_LEVELS];
  logic [CH_W-1:0]       granted_nxt;
  logic                  none_nxt;
  logic                  out_load;
  logic                  in_load;

  assign apb_req = '{psel: psel, penable: penable, pwrite: pwrite,
                     paddr: paddr, pwdata: pwdata};
  assign pready  = 1'b1;

  prra_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (apb_req),
    .prio_r (prio_r),
    .prdata (prdata)
  );

  prra_pick #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .NUM_LEVELS   (NUM_LEVELS)
  ) u_pick (
    .elig_mask (elig_r),
    .prev      (prev_r),
    .prio      (prio_r),
    .last_r    (last_r),
    .last_nxt  (last_nxt),
    .granted   (granted_nxt),
    .none      (none_nxt)
  );

  assign out_load = !out_v_r || !out_stall;
  assign in_load  = !in_v_r || out_load;
  assign in_stall = !in_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        last_r[l] <= '0;
      end
    end else begin
      if (in_load) begin
        in_v_r <= in_valid;
      end
      if (out_load) begin
        out_v_r <= in_v_r;
      end
      if (in_v_r && out_load) begin
        last_r <= last_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_load) begin
      elig_r <= in_device_connected_mask & in_controller_connected_mask &
                in_rx_ready_mask & in_tx_nonempty_mask;
      prev_r <= in_previous_channel;
    end
    if (in_v_r && out_load) begin
      granted_r <= granted_nxt;
      none_r    <= none_nxt;
    end
  end

  assign out_valid           = out_v_r;
  assign out_granted_channel = granted_r;
  assign out_none_eligible   = none_r;

endmodule

FILE: bench/tb_priority_round_robin_channel_arbiter.sv
module tb_priority_round_robin_channel_arbiter;
  timeunit 1ns;
  timeprecision 1ps;
  import prra_pkg::*;

  localparam int NCH = NUM_CHANNELS_DEF;
  localparam int NLVL = NUM_LEVELS_DEF;
  localparam int GRANT_W = $clog2(NCH + 1);
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 1'b1;
  localparam int RANDOM_PHASES = 8;
  localparam int WORDS_PER_PHASE = 160;

  typedef struct packed {
    logic [MASK_W-1:0] dev;
    logic [MASK_W-1:0] ctl;
    logic [MASK_W-1:0] rx;
    logic [MASK_W-1:0] tx;
    logic [PREV_W-1:0] prev;
  } channel_word_t;

  typedef struct packed {
    logic [GRANT_W-1:0] channel;
    logic               none;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [GRANT_W-1:0] out_granted_channel;
  logic out_none_eligible;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  channel_word_t on_wire = '0;
  logic in_taken = 1'b0;

  // predictor state
  logic [PRIO_REG_W-1:0] channel_levels = '0;
  logic [GRANT_W-1:0] served_at_level [NLVL] = '{default: '0};

  channel_word_t pending_words[$];
  grant_t grants_due[$];
  int words_in_flight = 0;
  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned in_gap_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned in_gap_left = 0;
  int unsigned out_stall_left = 0;
  grant_t got_grant;
  grant_t due_grant;

  priority_round_robin_channel_arbiter dut (
    .clk                          (clk),
    .rst_n                        (rst_n),
    .in_valid                     (in_valid),
    .in_stall                     (in_stall),
    .in_device_connected_mask     (on_wire.dev),
    .in_controller_connected_mask (on_wire.ctl),
    .in_rx_ready_mask             (on_wire.rx),
    .in_tx_nonempty_mask          (on_wire.tx),
    .in_previous_channel          (on_wire.prev),
    .out_valid                    (out_valid),
    .out_stall                    (out_stall),
    .out_granted_channel          (out_granted_channel),
    .out_none_eligible            (out_none_eligible),
    .psel                         (psel),
    .penable                      (penable),
    .pwrite                       (pwrite),
    .paddr                        (paddr),
    .pwdata                       (pwdata),
    .prdata                       (prdata),
    .pready                       (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // one pass from the channel after previous, lowest level wins, ties step
  // past the channel last served at that level
  function automatic grant_t pick_grant(channel_word_t w);
    logic [MASK_W-1:0] ready;
    int unsigned idx, sel, sel_lvl, lvl, i;
    grant_t g;
    ready = w.dev & w.ctl & w.rx & w.tx;
    idx = (int'(w.prev) + 1 >= NCH) ? 0 : w.prev + 1;
    sel = NCH;
    sel_lvl = 0;
    for (i = 0; i < NCH; i++) begin
      if (idx < MASK_W && ready[idx]) begin
        lvl = (PRIO_W * idx < PRIO_REG_W) ? channel_levels[PRIO_W * idx +: PRIO_W] : 0;
        if (lvl >= NLVL) begin
          lvl = NLVL - 1;
        end
        if (sel == NCH || lvl < sel_lvl) begin
          sel = idx;
          sel_lvl = lvl;
        end else if (lvl == sel_lvl && served_at_level[lvl] == sel) begin
          sel = idx;
          served_at_level[lvl] = GRANT_W'(NCH);
        end
      end
      idx = (idx + 1 == NCH) ? 0 : idx + 1;
    end
    if (sel != NCH) begin
      served_at_level[sel_lvl] = GRANT_W'(sel);
    end
    g.channel = GRANT_W'(sel);
    g.none = (sel == NCH);
    return g;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
  endtask

  // input word driver
  always @(negedge clk) begin
    if (in_valid && !in_taken) begin
      // stalled word holds
    end else if (in_gap_left != 0) begin
      in_valid <= 1'b0;
      in_gap_left--;
    end else if (pending_words.size() != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      in_gap_left = $urandom_range(0, 9);
    end else if (pending_words.size() != 0) begin
      on_wire <= pending_words.pop_front();
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result side stall bursts
  always @(negedge clk) begin
    if (out_stall_left != 0) begin
      out_stall <= 1'b1;
      out_stall_left--;
    end else if ($urandom_range(0, 99) < out_stall_pct) begin
      out_stall <= 1'b1;
      out_stall_left = $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (rst_n) begin
        if (psel && penable && pready) begin
          if (pwrite) begin
            if (paddr[ADDR_W-1:2] == REG_CHANNEL_PRIORITIES) begin
              channel_levels = pwdata[PRIO_REG_W-1:0];
            end
          end else if (paddr[ADDR_W-1:2] == REG_CHANNEL_PRIORITIES) begin
            if (prdata !== DATA_W'(channel_levels)) begin
              report_mismatch("channel_priorities readback", prdata, channel_levels);
            end
          end
        end
        if (in_valid && !in_stall) begin
          grants_due.push_back(pick_grant(on_wire));
        end
        if (out_valid && !out_stall) begin
          got_grant.channel = out_granted_channel;
          got_grant.none = out_none_eligible;
          if (grants_due.size() == 0) begin
            report_mismatch("grant word with none due", got_grant.channel, 0);
          end else begin
            due_grant = grants_due.pop_front();
            words_in_flight--;
            if (got_grant.channel !== due_grant.channel) begin
              report_mismatch("granted_channel", got_grant.channel, due_grant.channel);
            end
            if (got_grant.none !== due_grant.none) begin
              report_mismatch("none_eligible", got_grant.none, due_grant.none);
            end
          end
        end
      end
    end
  end

  task automatic apb_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
                            input logic [DATA_W-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic add_word(channel_word_t w);
    pending_words.push_back(w);
    words_in_flight++;
  endtask

  function automatic channel_word_t mk_word(logic [MASK_W-1:0] dev, logic [MASK_W-1:0] ctl,
                                            logic [MASK_W-1:0] rx, logic [MASK_W-1:0] tx,
                                            logic [PREV_W-1:0] prev);
    channel_word_t w;
    w.dev = dev;
    w.ctl = ctl;
    w.rx = rx;
    w.tx = tx;
    w.prev = prev;
    return w;
  endfunction

  // mostly a shared eligible set with extra bits per mask, repeated in runs so
  // the per-level rotation gets exercised; some plain noise
  task automatic add_random_words(int n);
    channel_word_t w;
    logic [MASK_W-1:0] elig;
    int left, rep;
    left = n;
    while (left > 0) begin
      case ($urandom_range(0, 3))
        0: elig = '1;
        1: elig = MASK_W'(1 << $urandom_range(0, MASK_W - 1));
        2: elig = MASK_W'($urandom);
        default: elig = MASK_W'($urandom & $urandom);
      endcase
      if ($urandom_range(0, 9) == 0) begin
        w = mk_word(MASK_W'($urandom), MASK_W'($urandom), MASK_W'($urandom),
                    MASK_W'($urandom), PREV_W'($urandom));
      end else begin
        w = mk_word(elig | MASK_W'($urandom & $urandom), elig | MASK_W'($urandom & $urandom),
                    elig | MASK_W'($urandom & $urandom), elig | MASK_W'($urandom & $urandom),
                    PREV_W'($urandom_range(0, NCH - 1)));
      end
      rep = $urandom_range(1, 6);
      if (rep > left) begin
        rep = left;
      end
      repeat (rep) add_word(w);
      left -= rep;
    end
  endtask

  task automatic wait_idle();
    while (words_in_flight != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 5;
      2: return 20;
      default: return 50;
    endcase
  endfunction

  function automatic logic [PRIO_REG_W-1:0] levels_for_phase(int p);
    logic [PRIO_REG_W-1:0] v;
    logic [PRIO_W-1:0] a, b;
    int c;
    v = '0;
    a = PRIO_W'($urandom);
    b = PRIO_W'($urandom);
    for (c = 0; c < PRIO_REG_W / PRIO_W; c++) begin
      case (p)
        0: v[PRIO_W * c +: PRIO_W] = '1;
        1: v[PRIO_W * c +: PRIO_W] = PRIO_W'(c);
        2, 6: v[PRIO_W * c +: PRIO_W] = PRIO_W'($urandom);
        4: v[PRIO_W * c +: PRIO_W] = PRIO_W'((PRIO_REG_W / PRIO_W) - 1 - c);
        5: v[PRIO_W * c +: PRIO_W] = '0;
        default: v[PRIO_W * c +: PRIO_W] = $urandom_range(0, 1) ? a : b;
      endcase
    end
    return v;
  endfunction

  initial begin
    logic [DATA_W-1:0] noise;
    int p, c;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    apb_access(1'b0, REG_CHANNEL_PRIORITIES, '0);

    // all levels zero after reset
    add_word(mk_word('0, '0, '0, '0, '0));
    for (c = 0; c < NCH; c++) begin
      add_word(mk_word('1, '1, '1, '1, PREV_W'(c)));
    end
    add_word(mk_word('0, '1, '1, '1, PREV_W'(3)));
    add_word(mk_word('1, '0, '1, '1, PREV_W'(3)));
    add_word(mk_word('1, '1, '0, '1, PREV_W'(3)));
    add_word(mk_word('1, '1, '1, '0, PREV_W'(3)));
    add_word(mk_word(8'hAA, '1, '1, '1, PREV_W'(NCH - 1)));
    add_word(mk_word(8'h80, 8'h80, 8'h80, 8'h80, PREV_W'(NCH - 1)));
    add_word(mk_word(8'h01, 8'h01, 8'h01, 8'h01, '0));
    add_word(mk_word(8'h55, 8'h0F, 8'hF0, 8'hFF, PREV_W'(5)));
    repeat (3) add_word(mk_word('1, '1, '1, '1, PREV_W'(NCH - 1)));
    wait_idle();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      in_gap_pct = 0;
      out_stall_pct = 0;
      noise = $urandom;
      apb_access(1'b1, REG_CHANNEL_PRIORITIES,
                 {noise[DATA_W-1:PRIO_REG_W], levels_for_phase(p)});
      if (p == 0 || p == 3) begin
        // unused index must leave the priorities alone
        apb_access(1'b1, REG_UNUSED, $urandom);
      end
      apb_access(1'b0, REG_CHANNEL_PRIORITIES, '0);
      if (p != RANDOM_PHASES - 1) begin
        in_gap_pct = pick_pct();
        out_stall_pct = pick_pct();
      end
      add_random_words(WORDS_PER_PHASE);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && grants_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
